[sv/csn_pkg.sv]
// ----------------------------------------------------------------------------
// csn_pkg: shared definitions for the conductance synapse step block
// Payload structs, register indexes, datapath widths and the magnesium
// block exponent table.
// ----------------------------------------------------------------------------
package csn_pkg;

    // Table size that the voltage index is clamped to by default
    localparam int MG_TABLE_ENTRIES_DEF = 256;

    // Exponent table: entry for integer mV m holds exp(-0.062 m)/3.57 in Q.24
    localparam int ROM_SPAN  = 256;
    localparam int ROM_ZERO  = 128;
    localparam int ROM_W     = 34;
    localparam int ROM_IDX_W = 8;
    localparam logic [63:0] ROM_BASE      = 64'd4699500;
    localparam logic [63:0] STEP_DOWN_Q32 = 64'd4036766275;
    localparam logic [63:0] STEP_UP_Q24   = 64'd17850326;

    // Shared multiplier
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Block factor divider: B = (2^52 + D/2) / D, D = 2^36 + Mg * e
    localparam int DIV_D_W     = 51;
    localparam int BLK_W       = 17;
    localparam int NUM_SHIFT   = 52;
    localparam int MG_ONE_SHIFT = 36;
    localparam logic [BLK_W-1:0] BLK_ONE = 17'h10000;

    // Calcium entry threshold, -20 mV in Q7.8
    localparam logic signed [15:0] CA_THRESHOLD = -16'sd5120;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECEPTOR_KIND = 3'd0,
        CFG_PEAK_COND     = 3'd1,
        CFG_COND_DECAY    = 3'd2,
        CFG_REV_POT       = 3'd3,
        CFG_MG_CONC       = 3'd4,
        CFG_CA_DECAY      = 3'd5,
        CFG_TIMESTEP      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic               spike;
        logic signed [15:0] post_voltage;
        logic signed [15:0] weight;
    } t_syn_in;

    typedef struct packed {
        logic signed [31:0] current;
        logic [31:0]        calcium_level;
    } t_syn_out;

    typedef struct packed {
        logic             done;
        logic [BLK_W-1:0] quot;
    } t_div_rsp;

    typedef logic [ROM_W-1:0] t_rom_arr [ROM_SPAN];

    // Build the exponent table by recurrence outward from 0 mV
    function automatic t_rom_arr mg_rom_build();
        t_rom_arr    rom;
        logic [63:0] e;
        int          i;
        e = ROM_BASE;
        rom[ROM_ZERO] = e[ROM_W-1:0];
        for (i = ROM_ZERO + 1; i < ROM_SPAN; i++) begin
            e = (e * STEP_DOWN_Q32 + 64'h8000_0000) >> 32;
            rom[i] = e[ROM_W-1:0];
        end
        e = ROM_BASE;
        for (i = ROM_ZERO - 1; i >= 0; i--) begin
            e = (e * STEP_UP_Q24 + 64'h0080_0000) >> 24;
            rom[i] = e[ROM_W-1:0];
        end
        return rom;
    endfunction

    localparam t_rom_arr MG_ROM = mg_rom_build();

endpackage

[sv/csn_mul.sv]
// ----------------------------------------------------------------------------
// csn_mul: shared unsigned multiplier
// One product per cycle with a registered result.
// ----------------------------------------------------------------------------
module csn_mul import csn_pkg::*; (
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_prod
);

    logic [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[sv/csn_div.sv]
// ----------------------------------------------------------------------------
// csn_div: restoring divider for the magnesium block factor
// Computes (2^52 + D/2) / D one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csn_div import csn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_D_W-1:0] i_divisor,
    output t_div_rsp           o_rsp
);

    localparam int CNT_W = $clog2(BLK_W);

    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_den;
    logic [BLK_W-1:0]   r_num;
    logic [BLK_W-1:0]   r_quot;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    assign trial = {r_rem, r_num[BLK_W-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Upper part of the dividend seeds the remainder, the low bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_divisor;
            r_rem  <= (DIV_D_W'(1) << (NUM_SHIFT - BLK_W)) + (i_divisor >> (BLK_W + 1));
            r_num  <= i_divisor[BLK_W:1];
            r_quot <= '0;
            r_cnt  <= CNT_W'(BLK_W - 1);
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            r_num  <= {r_num[BLK_W-2:0], 1'b0};
            r_quot <= {r_quot[BLK_W-2:0], ge};
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

[sv/conductance_synapse_nmda_step.sv]
// ----------------------------------------------------------------------------
// conductance_synapse_nmda_step: one timestep of a conductance synapse
// Decays and spikes the conductance, forms the synaptic current and, for
// NMDA receptors, the magnesium block and the calcium store.
// ----------------------------------------------------------------------------
// Each request is one timestep of one synapse. The block takes a request,
// raises o_in_stall while it works, and delivers one result per request.
// A plain receptor step runs from S_DECAY through S_RRND to S_DONE. An
// NMDA step adds the restoring divider for the magnesium block (17
// quotient bits, one per cycle) and the calcium states, and so makes
// seven passes through the single shared multiplier. The result sits in an
// output register, so the next request is taken while the previous result
// still waits on i_out_stall. Configuration writes are always ready and
// must only be issued while no request is in flight.
// ----------------------------------------------------------------------------
module conductance_synapse_nmda_step import csn_pkg::*; #(
    parameter int MG_TABLE_ENTRIES = MG_TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_syn_in               i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_syn_out              o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Voltage index clamp: table size limit, then physical table limit
    localparam int MG_HALF = MG_TABLE_ENTRIES / 2;
    localparam int MG_LO = (MG_HALF > ROM_ZERO) ? -ROM_ZERO : -MG_HALF;
    localparam int MG_HI = (MG_HALF - 1 > ROM_SPAN - ROM_ZERO - 1) ?
                           (ROM_SPAN - ROM_ZERO - 1) : (MG_HALF - 1);
    localparam logic signed [ROM_IDX_W:0] M_LO = (ROM_IDX_W + 1)'(MG_LO);
    localparam logic signed [ROM_IDX_W:0] M_HI = (ROM_IDX_W + 1)'(MG_HI);
    localparam logic signed [ROM_IDX_W:0] M_ZERO = (ROM_IDX_W + 1)'(ROM_ZERO);

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_DECAY = 15'h0002,
        S_COND  = 15'h0004,
        S_MGF   = 15'h0008,
        S_PROD  = 15'h0010,
        S_DIV   = 15'h0020,
        S_QMUL  = 15'h0040,
        S_QRND  = 15'h0080,
        S_RMUL  = 15'h0100,
        S_RRND  = 15'h0200,
        S_CAMUL = 15'h0400,
        S_CAADD = 15'h0800,
        S_CDMUL = 15'h1000,
        S_CDEC  = 15'h2000,
        S_DONE  = 15'h4000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic               r_kind;
    logic [23:0]        r_peak;
    logic [15:0]        r_cdecay;
    logic signed [15:0] r_erev;
    logic [15:0]        r_mg;
    logic [15:0]        r_cadecay;
    logic [15:0]        r_ts;

    // Synapse state
    logic [23:0]        r_cl;
    logic [31:0]        r_store;

    // Per-step working registers
    logic               r_spike;
    logic signed [15:0] r_v;
    logic [15:0]        r_dmag;
    logic [15:0]        r_wmag;
    logic               r_neg;
    logic [MUL_A_W-1:0] r_p;
    logic [BLK_W-1:0]   r_blk;
    logic [31:0]        r_cur;
    logic [31:0]        r_ca;

    // Output register
    t_syn_out           r_out;
    logic               r_out_valid;

    // Datapath wires
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;
    t_div_rsp           div_rsp;
    logic               div_start;
    logic [DIV_D_W-1:0] div_den;

    logic signed [16:0] df;
    logic signed [16:0] dabs;
    logic signed [16:0] wabs;
    logic signed [ROM_IDX_W:0] m_raw;
    logic signed [ROM_IDX_W:0] m_clamp;
    logic [ROM_IDX_W:0]        m_sum;
    logic [ROM_W-1:0]   rom_val;
    logic [24:0]        g_sum;
    logic [MUL_P_W-1:0] q_sum;
    logic [MUL_P_W-1:0] r_round;
    logic [36:0]        r_mag;
    logic [31:0]        cur_sat;
    logic               ca_ok;
    logic [MUL_P_W-1:0] inc_sum;
    logic [39:0]        ca_sum;

    // Driving force and weight magnitudes at acceptance
    assign df   = 17'(i_in_data.post_voltage) - 17'(r_erev);
    assign dabs = df[16] ? -df : df;
    assign wabs = i_in_data.weight[15] ? -17'(i_in_data.weight) : 17'(i_in_data.weight);

    // Table index: integer mV, clamped to the configured table span
    assign m_raw   = {r_v[15], r_v[15:8]};
    always_comb begin
        m_clamp = m_raw;
        if (m_raw < M_LO) begin
            m_clamp = M_LO;
        end
        if (m_raw > M_HI) begin
            m_clamp = M_HI;
        end
    end
    assign m_sum   = m_clamp + M_ZERO;
    assign rom_val = MG_ROM[m_sum[ROM_IDX_W-1:0]];

    // Conductance: decayed level plus spike, saturating at 24 bits
    assign g_sum = {1'b0, prod[39:16]} + (r_spike ? {1'b0, r_peak} : 25'd0);

    // Current rounding and saturation on the magnitude
    assign q_sum   = prod + MUL_P_W'(32'h0000_8000);
    assign r_round = prod + MUL_P_W'(32'h0008_0000);
    assign r_mag   = r_round[56:20];
    always_comb begin
        if (r_neg) begin
            cur_sat = (r_mag > 37'h0_8000_0000) ? 32'h8000_0000 : (~r_mag[31:0] + 32'd1);
        end else begin
            cur_sat = (r_mag > 37'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_mag[31:0];
        end
    end

    // Calcium enters above threshold on a positive current only
    assign ca_ok   = (r_v > CA_THRESHOLD) && ($signed(r_cur) > 32'sd0);
    assign inc_sum = prod + MUL_P_W'(8'd128);
    assign ca_sum  = {8'd0, r_store} + inc_sum[47:8];

    // Divisor: one plus Mg times the table entry
    assign div_den   = {1'b0, prod[49:0]} + (DIV_D_W'(1) << MG_ONE_SHIFT);
    assign div_start = (r_state == S_MGF) && r_kind;

    // Steer the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DECAY: begin
                mul_a = MUL_A_W'(r_cl);
                mul_b = MUL_B_W'(r_cdecay);
            end
            S_COND: begin
                mul_a = MUL_A_W'(rom_val);
                mul_b = MUL_B_W'(r_mg);
            end
            S_MGF: begin
                mul_a = MUL_A_W'(r_cl);
                mul_b = MUL_B_W'(r_dmag);
            end
            S_QMUL: begin
                mul_a = r_p;
                mul_b = r_blk;
            end
            S_RMUL: begin
                mul_a = r_p;
                mul_b = MUL_B_W'(r_wmag);
            end
            S_CAMUL: begin
                mul_a = ca_ok ? MUL_A_W'(r_cur[30:0]) : '0;
                mul_b = MUL_B_W'(r_ts);
            end
            S_CDMUL: begin
                mul_a = MUL_A_W'(r_ca);
                mul_b = MUL_B_W'(r_cadecay);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    csn_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    csn_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (div_den),
        .o_rsp     (div_rsp)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_DECAY;
            S_DECAY: n_state = S_COND;
            S_COND:  n_state = S_MGF;
            S_MGF:   n_state = S_PROD;
            S_PROD:  n_state = r_kind ? S_DIV : S_QMUL;
            S_DIV:   if (div_rsp.done) n_state = S_QMUL;
            S_QMUL:  n_state = S_QRND;
            S_QRND:  n_state = S_RMUL;
            S_RMUL:  n_state = S_RRND;
            S_RRND:  n_state = r_kind ? S_CAMUL : S_DONE;
            S_CAMUL: n_state = S_CAADD;
            S_CAADD: n_state = S_CDMUL;
            S_CDMUL: n_state = S_CDEC;
            S_CDEC:  n_state = S_DONE;
            S_DONE:  if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes and synapse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= 1'b0;
            r_peak    <= 24'd65536;
            r_cdecay  <= 16'd39750;
            r_erev    <= 16'sd0;
            r_mg      <= 16'd4096;
            r_cadecay <= 16'd64884;
            r_ts      <= 16'd256;
            r_cl      <= '0;
            r_store   <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RECEPTOR_KIND: r_kind    <= i_cfg_data[0];
                    CFG_PEAK_COND:     r_peak    <= i_cfg_data;
                    CFG_COND_DECAY:    r_cdecay  <= i_cfg_data[15:0];
                    CFG_REV_POT:       r_erev    <= i_cfg_data[15:0];
                    CFG_MG_CONC:       r_mg      <= i_cfg_data[15:0];
                    CFG_CA_DECAY:      r_cadecay <= i_cfg_data[15:0];
                    CFG_TIMESTEP:      r_ts      <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_state == S_COND) begin
                r_cl <= g_sum[24] ? 24'hFF_FFFF : g_sum[23:0];
            end
            if (r_state == S_CDEC) begin
                r_store <= prod[47:16];
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_spike <= i_in_data.spike;
                r_v     <= i_in_data.post_voltage;
                r_dmag  <= dabs[15:0];
                r_wmag  <= wabs[15:0];
                r_neg   <= df[16] ^ i_in_data.weight[15];
            end
            S_PROD: begin
                r_p   <= prod[MUL_A_W-1:0];
                r_blk <= BLK_ONE;
            end
            S_DIV:   r_blk <= div_rsp.quot;
            S_QRND:  r_p   <= q_sum[55:16];
            S_RRND:  r_cur <= cur_sat;
            S_CAADD: r_ca  <= (|ca_sum[39:32]) ? 32'hFFFF_FFFF : ca_sum[31:0];
            default: ;
        endcase
    end

    // Output register: load when the slot is free, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_out_valid || !i_out_stall)) begin
            r_out.current       <= r_cur;
            r_out.calcium_level <= r_kind ? r_store : 32'd0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

[sv/csn_chk.sv]
// ----------------------------------------------------------------------------
// csn_chk: port-level checks for the conductance synapse step block
// Watches the request, result and configuration ports over time.
// ----------------------------------------------------------------------------
module csn_chk import csn_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input t_syn_out              o_out_data,
    input logic                  i_out_stall,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic r_kind;

    // Track the receptor kind from configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_RECEPTOR_KIND)) begin
            r_kind <= i_cfg_data[0];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result changed while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken without going busy");

    a_plain_no_calcium: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !r_kind) |-> (o_out_data.calcium_level == 32'd0))
        else $error("calcium reported by a plain receptor");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid out of reset");

endmodule

bind conductance_synapse_nmda_step csn_chk u_csn_chk (.*);
